FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/svps_pkg.sv
// Types, constants and decode helpers for the vector pipe stall scoreboard.
`default_nettype none

package svps_pkg;

   localparam int LANES      = 4;
   localparam int REG_BITS   = 5;
   localparam int MASK_BITS  = 4;
   localparam int FIELD_BITS = REG_BITS + MASK_BITS;
   localparam int NUM_VREADS = 4;
   localparam int RSP_BITS   = 16;

   typedef struct packed {
      logic [REG_BITS-1:0]  regno;
      logic [MASK_BITS-1:0] mask;
   } vec_op_type;

   // writes of one pair, already cleared where the register is not tracked
   typedef struct packed {
      vec_op_type          lo;
      vec_op_type          hi;
      logic [REG_BITS-1:0] int_reg;
      logic                int_en;
   } wr_info_type;

   function automatic logic reg_ok(input logic [REG_BITS-1:0] regno, input int num_regs);
      return (regno != '0) && (int'(regno) < num_regs);
   endfunction

   function automatic vec_op_type decode_vec(input logic [FIELD_BITS-1:0] field,
                                             input int num_regs);
      vec_op_type op;
      op.regno = field[FIELD_BITS-1:MASK_BITS];
      op.mask  = field[MASK_BITS-1:0];
      if (!reg_ok(op.regno, num_regs)) begin
         op.mask = '0;
      end
      return op;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/svps_lane.sv
// One lane of the dependency check: which window entries wrote a lane that is read.
`default_nettype none

module svps_lane
   import svps_pkg::*;
#(
   parameter int WIN_DEPTH = 3,
   parameter int LANE      = 0
) (
   input  vec_op_type            rd_op     [NUM_VREADS],
   input  wr_info_type           win_info  [WIN_DEPTH],
   input  logic [WIN_DEPTH-1:0]  win_valid,
   output logic [WIN_DEPTH-1:0]  hit
);

   always_comb begin
      hit = '0;
      for (int k = 0; k < WIN_DEPTH; k++) begin
         for (int r = 0; r < NUM_VREADS; r++) begin
            if (win_valid[k] && rd_op[r].mask[LANE]) begin
               if ((win_info[k].lo.mask[LANE] && (win_info[k].lo.regno == rd_op[r].regno)) ||
                   (win_info[k].hi.mask[LANE] && (win_info[k].hi.regno == rd_op[r].regno))) begin
                  hit[k] = 1'b1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/svps_merge.sv
// Merge stage: combines lane and integer hits and works out the issue time.
`default_nettype none

module svps_merge
   import svps_pkg::*;
#(
   parameter int WIN_DEPTH   = 3,
   parameter int MAC_LATENCY = 4,
   parameter int TIME_BITS   = 16
) (
   input  logic [WIN_DEPTH-1:0] lane_hit  [LANES],
   input  logic [REG_BITS-1:0]  int_rd_a,
   input  logic                 int_rd_a_en,
   input  logic [REG_BITS-1:0]  int_rd_b,
   input  logic                 int_rd_b_en,
   input  wr_info_type          win_info  [WIN_DEPTH],
   input  logic [TIME_BITS-1:0] win_time  [WIN_DEPTH],
   input  logic [WIN_DEPTH-1:0] win_valid,
   input  logic [TIME_BITS-1:0] pipe_time,
   output logic [TIME_BITS-1:0] ready_time,
   output logic [TIME_BITS-1:0] pipe_next,
   output logic [RSP_BITS-1:0]  stall_out,
   output logic [RSP_BITS-1:0]  issue_out
);

   localparam int EXT_BITS = (TIME_BITS > RSP_BITS) ? TIME_BITS : RSP_BITS;

   logic [WIN_DEPTH-1:0] hit;
   logic [WIN_DEPTH-1:0] sel;
   logic [TIME_BITS-1:0] hit_time;
   logic [TIME_BITS-1:0] issue;
   logic [TIME_BITS:0]   sum_lat;
   logic [TIME_BITS:0]   sum_one;
   logic [EXT_BITS-1:0]  issue_ext;
   logic [EXT_BITS-1:0]  stall_ext;

   always_comb begin
      hit = '0;
      for (int k = 0; k < WIN_DEPTH; k++) begin
         for (int l = 0; l < LANES; l++) begin
            hit[k] = hit[k] | lane_hit[l][k];
         end
         if (win_valid[k] && win_info[k].int_en &&
             ((int_rd_a_en && (int_rd_a == win_info[k].int_reg)) ||
              (int_rd_b_en && (int_rd_b == win_info[k].int_reg)))) begin
            hit[k] = 1'b1;
         end
      end
   end

   // entry 0 is the newest; ready times only grow with age going down,
   // so the newest hit carries the latest ready time
   always_comb begin
      hit_time = '0;
      for (int k = 0; k < WIN_DEPTH; k++) begin
         sel[k] = hit[k] &&
                  !(|(hit & WIN_DEPTH'((64'd1 << k) - 64'd1)));
         if (sel[k]) begin
            hit_time = hit_time | win_time[k];
         end
      end
   end

   always_comb begin
      issue   = (hit_time > pipe_time) ? hit_time : pipe_time;
      sum_lat = {1'b0, issue} + (TIME_BITS+1)'(MAC_LATENCY);
      sum_one = {1'b0, issue} + (TIME_BITS+1)'(1);
      ready_time = sum_lat[TIME_BITS] ? '1 : sum_lat[TIME_BITS-1:0];
      pipe_next  = sum_one[TIME_BITS] ? '1 : sum_one[TIME_BITS-1:0];
      issue_ext  = EXT_BITS'(issue);
      stall_ext  = EXT_BITS'(issue - pipe_time);
      issue_out  = issue_ext[RSP_BITS-1:0];
      stall_out  = stall_ext[RSP_BITS-1:0];
   end

endmodule

`default_nettype wire

FILE: rtl/vector_pipe_stall_scoreboard.sv
// Top level of the vector pipe stall scoreboard.
`default_nettype none

// Takes one decoded instruction pair per cycle while req_stall is low and
// returns its stall and issue time from a registered output. A ready time
// written more than MAC_LATENCY-1 pairs ago can never exceed the current pipe
// time, so the scoreboard keeps only a window of the last MAC_LATENCY-1 pairs'
// writes; four lane checkers and an integer check compare the reads against
// that window in parallel and a merge stage picks the newest match. The rate
// is set by the loop from the window and pipe time through the merge compare
// and saturating add back into the window. A two-entry output buffer absorbs
// rsp_stall; req_stall rises only when both entries hold results. No clearing
// pass is needed after reset or start_block.
module vector_pipe_stall_scoreboard
   import svps_pkg::*;
#(
   parameter int MAC_LATENCY = 4,
   parameter int NUM_REGS    = 32,
   parameter int TIME_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_start_block,
   input  logic [FIELD_BITS-1:0] req_lo_read_a,
   input  logic [FIELD_BITS-1:0] req_lo_read_b,
   input  logic [FIELD_BITS-1:0] req_hi_read_a,
   input  logic [FIELD_BITS-1:0] req_hi_read_b,
   input  logic [REG_BITS-1:0]   req_int_read_a,
   input  logic [REG_BITS-1:0]   req_int_read_b,
   input  logic [FIELD_BITS-1:0] req_lo_write,
   input  logic [FIELD_BITS-1:0] req_hi_write,
   input  logic [REG_BITS-1:0]   req_int_load_write,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [RSP_BITS-1:0]   rsp_stall_cycles,
   output logic [RSP_BITS-1:0]   rsp_issue_time
);

   localparam int WIN_DEPTH = (MAC_LATENCY > 1) ? MAC_LATENCY - 1 : 1;

   // window of recent writes
   wr_info_type          win_info_ff  [WIN_DEPTH];
   wr_info_type          win_info_in  [WIN_DEPTH];
   logic [TIME_BITS-1:0] win_time_ff  [WIN_DEPTH];
   logic [TIME_BITS-1:0] win_time_in  [WIN_DEPTH];
   logic [WIN_DEPTH-1:0] win_valid_ff;
   logic [WIN_DEPTH-1:0] win_valid_in;
   logic [TIME_BITS-1:0] pipe_ff;
   logic [TIME_BITS-1:0] pipe_in;

   // output buffer
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]  rsp_cycles_ff, rsp_cycles_in;
   logic [RSP_BITS-1:0]  rsp_issue_ff, rsp_issue_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic [RSP_BITS-1:0]  skid_cycles_ff, skid_cycles_in;
   logic [RSP_BITS-1:0]  skid_issue_ff, skid_issue_in;

   logic                 accept;
   logic                 pop;
   vec_op_type           rd_op [NUM_VREADS];
   wr_info_type          new_info;
   logic [WIN_DEPTH-1:0] win_valid_eff;
   logic [TIME_BITS-1:0] pipe_eff;
   logic [WIN_DEPTH-1:0] lane_hit [LANES];
   logic [TIME_BITS-1:0] ready_time;
   logic [TIME_BITS-1:0] pipe_next;
   logic [RSP_BITS-1:0]  stall_out;
   logic [RSP_BITS-1:0]  issue_out;

   assign accept    = req_valid && !skid_valid_ff;
   assign pop       = rsp_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_stall_cycles = rsp_cycles_ff;
   assign rsp_issue_time   = rsp_issue_ff;

   always_comb begin
      rd_op[0] = decode_vec(req_lo_read_a, NUM_REGS);
      rd_op[1] = decode_vec(req_lo_read_b, NUM_REGS);
      rd_op[2] = decode_vec(req_hi_read_a, NUM_REGS);
      rd_op[3] = decode_vec(req_hi_read_b, NUM_REGS);
      new_info.lo      = decode_vec(req_lo_write, NUM_REGS);
      new_info.hi      = decode_vec(req_hi_write, NUM_REGS);
      new_info.int_reg = req_int_load_write;
      new_info.int_en  = reg_ok(req_int_load_write, NUM_REGS);
      // start_block wipes history before this transaction is checked
      win_valid_eff = req_start_block ? '0 : win_valid_ff;
      pipe_eff      = req_start_block ? '0 : pipe_ff;
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      svps_lane #(
         .WIN_DEPTH (WIN_DEPTH),
         .LANE      (l)
      ) u_lane (
         .rd_op     (rd_op),
         .win_info  (win_info_ff),
         .win_valid (win_valid_eff),
         .hit       (lane_hit[l])
      );
   end

   svps_merge #(
      .WIN_DEPTH   (WIN_DEPTH),
      .MAC_LATENCY (MAC_LATENCY),
      .TIME_BITS   (TIME_BITS)
   ) u_merge (
      .lane_hit    (lane_hit),
      .int_rd_a    (req_int_read_a),
      .int_rd_a_en (reg_ok(req_int_read_a, NUM_REGS)),
      .int_rd_b    (req_int_read_b),
      .int_rd_b_en (reg_ok(req_int_read_b, NUM_REGS)),
      .win_info    (win_info_ff),
      .win_time    (win_time_ff),
      .win_valid   (win_valid_eff),
      .pipe_time   (pipe_eff),
      .ready_time  (ready_time),
      .pipe_next   (pipe_next),
      .stall_out   (stall_out),
      .issue_out   (issue_out)
   );

   always_comb begin
      win_info_in  = win_info_ff;
      win_time_in  = win_time_ff;
      win_valid_in = win_valid_ff;
      pipe_in      = pipe_ff;
      if (accept) begin
         win_info_in[0]  = new_info;
         win_time_in[0]  = ready_time;
         win_valid_in[0] = 1'b1;
         for (int k = 1; k < WIN_DEPTH; k++) begin
            win_info_in[k]  = win_info_ff[k-1];
            win_time_in[k]  = win_time_ff[k-1];
            win_valid_in[k] = win_valid_eff[k-1];
         end
         pipe_in = pipe_next;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_cycles_in  = rsp_cycles_ff;
      rsp_issue_in   = rsp_issue_ff;
      skid_valid_in  = skid_valid_ff;
      skid_cycles_in = skid_cycles_ff;
      skid_issue_in  = skid_issue_ff;
      if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_cycles_in = skid_cycles_ff;
            rsp_issue_in  = skid_issue_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in  = accept;
            rsp_cycles_in = stall_out;
            rsp_issue_in  = issue_out;
         end
      end else if (accept) begin
         skid_valid_in  = 1'b1;
         skid_cycles_in = stall_out;
         skid_issue_in  = issue_out;
      end
   end

   always_ff @(posedge clock) begin
      win_info_ff    <= win_info_in;
      win_time_ff    <= win_time_in;
      rsp_cycles_ff  <= rsp_cycles_in;
      rsp_issue_ff   <= rsp_issue_in;
      skid_cycles_ff <= skid_cycles_in;
      skid_issue_ff  <= skid_issue_in;
      if (reset) begin
         win_valid_ff  <= '0;
         pipe_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         win_valid_ff  <= win_valid_in;
         pipe_ff       <= pipe_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/svps_checker.sv
// Port-level checker for the vector pipe stall scoreboard, with its bind.
`default_nettype none
`include "assert_macros.svh"

module svps_checker
   import svps_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                req_start_block,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [RSP_BITS-1:0] rsp_stall_cycles,
   input wire logic [RSP_BITS-1:0] rsp_issue_time
);

   // a held result keeps its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                rsp_valid && $stable(rsp_stall_cycles) && $stable(rsp_issue_time))

   // the input side only backs up once a result is waiting
   `ASSERT_IMPLY(a_stall_needs_rsp, clock, reset, req_stall, rsp_valid)

   // a start transaction into a free output sees an empty scoreboard
   `ASSERT_NEXT(a_start_zero, clock, reset,
                req_valid && !req_stall && req_start_block && (!rsp_valid || !rsp_stall),
                rsp_valid && (rsp_issue_time == '0) && (rsp_stall_cycles == '0))

   // any transaction into a free output shows up the next cycle
   `ASSERT_NEXT(a_rsp_follows, clock, reset,
                req_valid && !req_stall && (!rsp_valid || !rsp_stall), rsp_valid)

endmodule

bind vector_pipe_stall_scoreboard svps_checker u_svps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_start_block  (req_start_block),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_stall_cycles (rsp_stall_cycles),
   .rsp_issue_time   (rsp_issue_time)
);

`default_nettype wire

FILE: tb/issue_checker.sv
// Checker: predicts stall and issue time for every accepted pair and compares the results.
module issue_checker
   import svps_pkg::*;
#(
   parameter int MAC_LATENCY = 4,
   parameter int NUM_REGS    = 32,
   parameter int TIME_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_start_block,
   input  logic [FIELD_BITS-1:0] req_lo_read_a,
   input  logic [FIELD_BITS-1:0] req_lo_read_b,
   input  logic [FIELD_BITS-1:0] req_hi_read_a,
   input  logic [FIELD_BITS-1:0] req_hi_read_b,
   input  logic [REG_BITS-1:0]   req_int_read_a,
   input  logic [REG_BITS-1:0]   req_int_read_b,
   input  logic [FIELD_BITS-1:0] req_lo_write,
   input  logic [FIELD_BITS-1:0] req_hi_write,
   input  logic [REG_BITS-1:0]   req_int_load_write,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [RSP_BITS-1:0]   rsp_stall_cycles,
   input  logic [RSP_BITS-1:0]   rsp_issue_time,
   output int                    fail_count,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned TIME_MAX = (64'd1 << TIME_BITS) - 1;

   typedef logic [TIME_BITS-1:0] tick_type;

   typedef struct packed {
      logic [RSP_BITS-1:0] stall_cycles;
      logic [RSP_BITS-1:0] issue_time;
   } timing_type;

   tick_type   lane_ready [NUM_REGS*LANES];
   tick_type   int_ready  [NUM_REGS];
   tick_type   pipe_now;
   timing_type timing_q [$];
   int         errors = 0;

   function automatic tick_type sat_add(tick_type t, int unsigned amount);
      longint unsigned sum;
      sum = t;
      sum += amount;
      return (sum > TIME_MAX) ? tick_type'(TIME_MAX) : tick_type'(sum);
   endfunction

   function automatic bit tracked(logic [REG_BITS-1:0] r);
      return (r != '0) && (int'(r) < NUM_REGS);
   endfunction

   function automatic tick_type vec_wait(tick_type t, logic [FIELD_BITS-1:0] f);
      logic [REG_BITS-1:0]  r;
      logic [MASK_BITS-1:0] m;
      tick_type             latest;
      r = f[FIELD_BITS-1:MASK_BITS];
      m = f[MASK_BITS-1:0];
      latest = t;
      if (tracked(r)) begin
         for (int i = 0; i < LANES; i++) begin
            if (m[i] && lane_ready[int'(r)*LANES+i] > latest) begin
               latest = lane_ready[int'(r)*LANES+i];
            end
         end
      end
      return latest;
   endfunction

   function automatic tick_type int_wait(tick_type t, logic [REG_BITS-1:0] r);
      if (tracked(r) && int_ready[r] > t) begin
         return int_ready[r];
      end
      return t;
   endfunction

   function automatic void vec_mark(logic [FIELD_BITS-1:0] f, tick_type ready);
      logic [REG_BITS-1:0]  r;
      logic [MASK_BITS-1:0] m;
      r = f[FIELD_BITS-1:MASK_BITS];
      m = f[MASK_BITS-1:0];
      if (tracked(r)) begin
         for (int i = 0; i < LANES; i++) begin
            if (m[i]) begin
               lane_ready[int'(r)*LANES+i] = ready;
            end
         end
      end
   endfunction

   function automatic void clear_times();
      foreach (lane_ready[i]) lane_ready[i] = '0;
      foreach (int_ready[i]) int_ready[i] = '0;
      pipe_now = '0;
   endfunction

   always @(posedge clock) begin
      timing_type want;
      tick_type   issue;
      tick_type   ready;
      if (reset) begin
         clear_times();
         timing_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (timing_q.size() == 0) begin
               $display("%0t: unexpected result: stall_cycles %0d, issue_time %0d",
                        $time, rsp_stall_cycles, rsp_issue_time);
               errors++;
            end else begin
               want = timing_q.pop_front();
               if (rsp_stall_cycles !== want.stall_cycles) begin
                  $display("%0t: stall_cycles mismatch: expected %0d, actual %0d",
                           $time, want.stall_cycles, rsp_stall_cycles);
                  errors++;
               end
               if (rsp_issue_time !== want.issue_time) begin
                  $display("%0t: issue_time mismatch: expected %0d, actual %0d",
                           $time, want.issue_time, rsp_issue_time);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_start_block) begin
               clear_times();
            end
            issue = pipe_now;
            issue = vec_wait(issue, req_lo_read_a);
            issue = vec_wait(issue, req_lo_read_b);
            issue = vec_wait(issue, req_hi_read_a);
            issue = vec_wait(issue, req_hi_read_b);
            issue = int_wait(issue, req_int_read_a);
            issue = int_wait(issue, req_int_read_b);
            want.stall_cycles = RSP_BITS'(issue - pipe_now);
            want.issue_time   = RSP_BITS'(issue);
            timing_q.push_back(want);
            // upper slot goes last so it wins on a shared lane
            ready = sat_add(issue, MAC_LATENCY);
            vec_mark(req_lo_write, ready);
            if (tracked(req_int_load_write)) begin
               int_ready[req_int_load_write] = ready;
            end
            vec_mark(req_hi_write, ready);
            pipe_now = sat_add(issue, 1);
         end
      end
      fail_count <= errors;
      pending    <= timing_q.size();
   end

endmodule

FILE: tb/tb.sv
// Testbench top: drives instruction pairs and result stalls, and gives the verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import svps_pkg::*;

   localparam int MAC_LATENCY    = 4;
   localparam int NUM_REGS       = 32;
   localparam int TIME_BITS      = 16;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int CHAIN_PAIRS    = 60;

   typedef struct packed {
      logic                  start_block;
      logic [FIELD_BITS-1:0] lo_read_a;
      logic [FIELD_BITS-1:0] lo_read_b;
      logic [FIELD_BITS-1:0] hi_read_a;
      logic [FIELD_BITS-1:0] hi_read_b;
      logic [REG_BITS-1:0]   int_read_a;
      logic [REG_BITS-1:0]   int_read_b;
      logic [FIELD_BITS-1:0] lo_write;
      logic [FIELD_BITS-1:0] hi_write;
      logic [REG_BITS-1:0]   int_load_write;
   } pair_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_start_block;
   logic [FIELD_BITS-1:0] req_lo_read_a;
   logic [FIELD_BITS-1:0] req_lo_read_b;
   logic [FIELD_BITS-1:0] req_hi_read_a;
   logic [FIELD_BITS-1:0] req_hi_read_b;
   logic [REG_BITS-1:0]   req_int_read_a;
   logic [REG_BITS-1:0]   req_int_read_b;
   logic [FIELD_BITS-1:0] req_lo_write;
   logic [FIELD_BITS-1:0] req_hi_write;
   logic [REG_BITS-1:0]   req_int_load_write;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [RSP_BITS-1:0]   rsp_stall_cycles;
   logic [RSP_BITS-1:0]   rsp_issue_time;
   int                    fail_count;
   int                    pending;

   int send_gap_pct = 0;
   int stall_pct    = 0;
   int hold_asks    = 0;

   vector_pipe_stall_scoreboard #(
      .MAC_LATENCY (MAC_LATENCY),
      .NUM_REGS    (NUM_REGS),
      .TIME_BITS   (TIME_BITS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_start_block    (req_start_block),
      .req_lo_read_a      (req_lo_read_a),
      .req_lo_read_b      (req_lo_read_b),
      .req_hi_read_a      (req_hi_read_a),
      .req_hi_read_b      (req_hi_read_b),
      .req_int_read_a     (req_int_read_a),
      .req_int_read_b     (req_int_read_b),
      .req_lo_write       (req_lo_write),
      .req_hi_write       (req_hi_write),
      .req_int_load_write (req_int_load_write),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_stall_cycles   (rsp_stall_cycles),
      .rsp_issue_time     (rsp_issue_time)
   );

   issue_checker #(
      .MAC_LATENCY (MAC_LATENCY),
      .NUM_REGS    (NUM_REGS),
      .TIME_BITS   (TIME_BITS)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_start_block    (req_start_block),
      .req_lo_read_a      (req_lo_read_a),
      .req_lo_read_b      (req_lo_read_b),
      .req_hi_read_a      (req_hi_read_a),
      .req_hi_read_b      (req_hi_read_b),
      .req_int_read_a     (req_int_read_a),
      .req_int_read_b     (req_int_read_b),
      .req_lo_write       (req_lo_write),
      .req_hi_write       (req_hi_write),
      .req_int_load_write (req_int_load_write),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_stall_cycles   (rsp_stall_cycles),
      .rsp_issue_time     (rsp_issue_time),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mostly a few hot registers so that reads land on writes still in flight
   function automatic logic [REG_BITS-1:0] rand_reg();
      if ($urandom_range(0, 99) < 85) begin
         return REG_BITS'($urandom_range(0, 3));
      end
      return REG_BITS'($urandom);
   endfunction

   function automatic logic [FIELD_BITS-1:0] rand_vec();
      return {rand_reg(), MASK_BITS'($urandom)};
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      p.start_block    = ($urandom_range(0, 99) < 2);
      p.lo_read_a      = rand_vec();
      p.lo_read_b      = rand_vec();
      p.hi_read_a      = rand_vec();
      p.hi_read_b      = rand_vec();
      p.int_read_a     = rand_reg();
      p.int_read_b     = rand_reg();
      p.lo_write       = rand_vec();
      p.hi_write       = rand_vec();
      p.int_load_write = rand_reg();
      return p;
   endfunction

   task automatic send_pair(input pair_type p);
      while (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_start_block    <= p.start_block;
      req_lo_read_a      <= p.lo_read_a;
      req_lo_read_b      <= p.lo_read_b;
      req_hi_read_a      <= p.hi_read_a;
      req_hi_read_b      <= p.hi_read_b;
      req_int_read_a     <= p.int_read_a;
      req_int_read_b     <= p.int_read_b;
      req_lo_write       <= p.lo_write;
      req_hi_write       <= p.hi_write;
      req_int_load_write <= p.int_load_write;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic run_phase(input int gap_pct, input int rsp_pct, input int count);
      pair_type p;
      send_gap_pct = gap_pct;
      stall_pct   <= rsp_pct;
      p = random_pair();
      p.start_block = 1'b1;
      send_pair(p);
      repeat (count - 1) send_pair(random_pair());
      wait_drain();
   endtask

   // receiver: random stalls, plus long hold-offs on request
   initial begin
      int hold_left;
      int holds_taken;
      hold_left   = 0;
      holds_taken = 0;
      rsp_stall   = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_taken != hold_asks) begin
            holds_taken++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      pair_type p;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_start_block    = 1'b0;
      req_lo_read_a      = '0;
      req_lo_read_b      = '0;
      req_hi_read_a      = '0;
      req_hi_read_b      = '0;
      req_int_read_a     = '0;
      req_int_read_b     = '0;
      req_lo_write       = '0;
      req_hi_write       = '0;
      req_int_load_write = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed transactions
      p = '0; p.start_block = 1'b1;
      send_pair(p);
      p = '1;
      send_pair(p);
      // read back everything just written to register 31
      p = '1; p.start_block = 1'b0; p.lo_write = '0; p.hi_write = '0; p.int_load_write = '0;
      send_pair(p);
      p = '0; p.lo_write = {5'd1, 4'hF}; p.hi_write = {5'd2, 4'h3}; p.int_load_write = 5'd5;
      send_pair(p);
      p = '0; p.lo_read_a = {5'd1, 4'h1};
      send_pair(p);
      // register zero is never recorded nor checked
      p = '0; p.lo_write = {5'd0, 4'hF}; p.hi_write = {5'd0, 4'hF};
      send_pair(p);
      p = '0; p.lo_read_a = {5'd0, 4'hF}; p.lo_read_b = {5'd0, 4'hF};
      p.hi_read_a = {5'd0, 4'hF}; p.hi_read_b = {5'd0, 4'hF};
      send_pair(p);
      // single lane write, then reads that miss and hit that lane
      p = '0; p.hi_write = {5'd3, 4'h4};
      send_pair(p);
      p = '0; p.lo_read_b = {5'd3, 4'hB};
      send_pair(p);
      p = '0; p.hi_read_a = {5'd3, 4'h4};
      send_pair(p);
      p = '0; p.hi_write = {5'd3, 4'h8};
      send_pair(p);
      p = '0; p.hi_read_b = {5'd3, 4'h8};
      send_pair(p);
      // empty lane mask reads nothing
      p = '0; p.lo_write = {5'd1, 4'hF};
      send_pair(p);
      p = '0; p.lo_read_a = {5'd1, 4'h0};
      send_pair(p);
      p = '0; p.int_load_write = 5'd5;
      send_pair(p);
      p = '0; p.int_read_b = 5'd5;
      send_pair(p);
      p = '0; p.int_load_write = 5'd6;
      send_pair(p);
      p = '0; p.int_read_a = 5'd6; p.int_read_b = 5'd31;
      send_pair(p);
      // both slots write lanes 0 and 1 of the same register
      p = '0; p.lo_write = {5'd4, 4'hF}; p.hi_write = {5'd4, 4'h3};
      send_pair(p);
      p = '0; p.hi_read_b = {5'd4, 4'h3};
      send_pair(p);
      p = '0; p.lo_write = {5'd4, 4'hF};
      send_pair(p);
      // start_block wipes the pending write
      p = '0; p.start_block = 1'b1; p.lo_read_a = {5'd4, 4'hF};
      send_pair(p);
      wait_drain();

      // dependent chain: each pair after the first waits on the write of the one before
      p = '0; p.start_block = 1'b1; p.lo_read_a = {5'd7, 4'h1}; p.lo_write = {5'd7, 4'h1};
      send_pair(p);
      p.start_block = 1'b0;
      repeat (CHAIN_PAIRS) send_pair(p);
      repeat (8) begin
         p = random_pair();
         p.start_block = 1'b0;
         send_pair(p);
      end
      wait_drain();

      run_phase(0, 0, 200);
      // long receiver hold-off while pairs keep coming
      hold_asks <= hold_asks + 1;
      repeat (40) send_pair(random_pair());
      wait_drain();
      run_phase(59, 0, 250);
      run_phase(0, 59, 250);
      run_phase(33, 33, 250);

      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/svps_pkg.sv
rtl/svps_lane.sv
rtl/svps_merge.sv
rtl/vector_pipe_stall_scoreboard.sv
rtl/svps_checker.sv
tb/issue_checker.sv
tb/tb.sv
